FILE: design/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants for the sorted-insert median tracker
// Store depth, index and count widths, sequencer states and the structs
// that travel between the cell row, the selection tree and the top level.
// ----------------------------------------------------------------------------
package smt_pkg;

	// store geometry
	localparam int DEPTH   = 64;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int MED_W   = WORD_W + 1;
	localparam int COUNT_W = 7;

	// selection tree: groups of GRP cells reduced in the first stage
	localparam int GRP  = 8;
	localparam int NGRP = (DEPTH + GRP - 1) / GRP;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic  ins_en;
		word_t value;
	} smt_bcast_t;

	// read positions for the selection tree
	typedef struct packed {
		idx_t lo_idx;
		idx_t hi_idx;
		idx_t max_idx;
	} smt_sel_t;

	// values picked out of the row
	typedef struct packed {
		word_t lo;
		word_t hi;
		word_t max;
	} smt_pick_t;

	// sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEL,
		ST_OUT
	} smt_state_t;

endpackage

FILE: design/smt_cell.sv
// ----------------------------------------------------------------------------
// smt_cell: one entry of the sorted row
// Holds one value. On an insert it keeps its value when smaller than the new
// one, takes the new value when it is the insert point, else takes the value
// of its left neighbor (shift right by one).
// ----------------------------------------------------------------------------
module smt_cell (
	input  logic               clk,
	input  smt_pkg::smt_bcast_t bcast,
	input  logic               valid,
	input  logic               left_lt,
	input  smt_pkg::word_t     left_entry,
	output smt_pkg::word_t     entry,
	output logic               lt
);
	import smt_pkg::*;

	word_t entry_q;

	// this entry stays in place when it is a live entry below the new value
	assign lt    = valid && (entry_q < bcast.value);
	assign entry = entry_q;

	// insert point or shift
	always_ff @(posedge clk) begin
		if (bcast.ins_en && !lt) begin
			entry_q <= left_lt ? bcast.value : left_entry;
		end
	end

endmodule

FILE: design/smt_select.sv
// ----------------------------------------------------------------------------
// smt_select: registered AND-OR tree that picks three entries of the row
// First stage: per group of GRP cells, one-hot match on the cell index and
// an OR over the group, registered. Second stage: OR over the groups.
// ----------------------------------------------------------------------------
module smt_select (
	input  logic              clk,
	input  smt_pkg::word_t    entries [smt_pkg::DEPTH],
	input  smt_pkg::smt_sel_t sel,
	output smt_pkg::smt_pick_t pick
);
	import smt_pkg::*;

	word_t lo_s1  [NGRP];
	word_t hi_s1  [NGRP];
	word_t max_s1 [NGRP];

	// stage 1: group reduction
	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			word_t lo_acc, hi_acc, max_acc;
			lo_acc  = '0;
			hi_acc  = '0;
			max_acc = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					if (sel.lo_idx == IDX_W'(g * GRP + k))
						lo_acc = lo_acc | entries[g * GRP + k];
					if (sel.hi_idx == IDX_W'(g * GRP + k))
						hi_acc = hi_acc | entries[g * GRP + k];
					if (sel.max_idx == IDX_W'(g * GRP + k))
						max_acc = max_acc | entries[g * GRP + k];
				end
			end
			lo_s1[g]  <= lo_acc;
			hi_s1[g]  <= hi_acc;
			max_s1[g] <= max_acc;
		end
	end

	// stage 2: OR across groups
	always_comb begin
		pick = '0;
		for (int g = 0; g < NGRP; g++) begin
			pick.lo  = pick.lo  | lo_s1[g];
			pick.hi  = pick.hi  | hi_s1[g];
			pick.max = pick.max | max_s1[g];
		end
	end

endmodule

FILE: design/sorted_insert_median_tracker.sv
// ----------------------------------------------------------------------------
// sorted_insert_median_tracker: running min / max / median over a sorted row
// Values are inserted into a row of DEPTH cells kept in ascending order; a
// full row drops the value and flags it. Each beat yields one report.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | start / busy       | value
//  result   | done (strobe)      | min_value, max_value, median_doubled,
//           |                    | count, dropped
//
//  An item goes through the insert into the cell row, the first stage of the
//  selection tree, then the second stage plus the median add into the
//  result registers. done is high for one cycle, in the cycle busy drops,
//  so a new start can be taken in that same cycle.
//  Reset empties the row (count to zero); cell contents are not cleared.
//  The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module sorted_insert_median_tracker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [31:0]         value,
	output logic                       done,
	output logic signed [31:0]         min_value,
	output logic signed [31:0]         max_value,
	output logic signed [32:0]         median_doubled,
	output logic [6:0]                 count,
	output logic                       dropped
);
	import smt_pkg::*;

	smt_state_t state_q, state_d;
	cnt_t       count_q;
	logic       drop_q;
	logic       accept;
	logic       full;
	logic       sel_busy;
	logic       out_load;
	logic       done_q;

	smt_bcast_t bcast;
	word_t      entries [DEPTH];
	logic       lts     [DEPTH];
	smt_sel_t   sel;
	smt_pick_t  pick;
	cnt_t       half;
	cnt_t       lo_pos;
	cnt_t       max_pos;

	word_t              min_q, max_q;
	logic signed [MED_W-1:0] med_q;

	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_SEL;
			ST_SEL:  state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		sel_busy = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: sel_busy = 1'b0;
			ST_SEL:  sel_busy = 1'b1;
			ST_OUT: begin
				sel_busy = 1'b1;
				out_load = 1'b1;
			end
			default: sel_busy = 1'b0;
		endcase
	end

	assign busy = sel_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= out_load;
			if (accept) begin
				drop_q <= full;
				if (!full) count_q <= count_q + 1'b1;
			end
		end
	end

	// cell row
	assign bcast.ins_en = accept && !full;
	assign bcast.value  = value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			smt_cell u_cell (
				.clk        (clk),
				.bcast      (bcast),
				.valid      (CNT_W'(i) < count_q),
				.left_lt    (1'b1),
				.left_entry (value),
				.entry      (entries[i]),
				.lt         (lts[i])
			);
		end else begin : g_body
			smt_cell u_cell (
				.clk        (clk),
				.bcast      (bcast),
				.valid      (CNT_W'(i) < count_q),
				.left_lt    (lts[i-1]),
				.left_entry (entries[i-1]),
				.entry      (entries[i]),
				.lt         (lts[i])
			);
		end
	end

	// read positions: middle pair (same entry twice for an odd count), last
	assign half    = count_q >> 1;
	assign lo_pos  = count_q[0] ? half : half - 1'b1;
	assign max_pos = count_q - 1'b1;
	assign sel.lo_idx  = lo_pos[IDX_W-1:0];
	assign sel.hi_idx  = half[IDX_W-1:0];
	assign sel.max_idx = max_pos[IDX_W-1:0];

	smt_select u_select (
		.clk     (clk),
		.entries (entries),
		.sel     (sel),
		.pick    (pick)
	);

	// result registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			min_q <= entries[0];
			max_q <= pick.max;
			med_q <= MED_W'(pick.lo) + MED_W'(pick.hi);
		end
	end

	assign done           = done_q;
	assign min_value      = min_q;
	assign max_value      = max_q;
	assign median_doubled = med_q;
	assign count          = COUNT_W'(count_q);
	assign dropped        = drop_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> full)
		else $error("dropped beat with store not full");
`endif

endmodule
